// ===== rtl/rhc_pkg.sv =====
package rhc_pkg;

  // Field widths.
  localparam int PIXEL_W    = 16;
  localparam int ROW_W      = 10;
  localparam int CH_W       = 8;
  localparam int HUE_W      = 9;
  localparam int CLS_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // Divider operand widths. The hue numerator is 60 * |diff| (at most 15300),
  // the saturation numerator is delta * 255 (at most 65025).
  localparam int HUE_NUM_W = 14;
  localparam int SAT_NUM_W = 16;
  localparam int DIV_DEN_W = 8;
  localparam int DIV_QUO_W = 8;

  // Fixed red thresholds.
  localparam logic [CH_W-1:0] RED_MIN_SAT = 8'd120;
  localparam logic [CH_W-1:0] RED_MIN_VAL = 8'd60;

  // Register reset values.
  localparam logic [HUE_W-1:0] RST_RED_HUE_LOW_MAX  = 9'd10;
  localparam logic [HUE_W-1:0] RST_RED_HUE_HIGH_MIN = 9'd340;
  localparam logic [HUE_W-1:0] RST_ORANGE_HUE_MIN   = 9'd11;
  localparam logic [HUE_W-1:0] RST_ORANGE_HUE_MAX   = 9'd35;
  localparam logic [ROW_W-1:0] RST_OBSTACLE_ROW_MIN = 10'd80;
  localparam logic [ROW_W-1:0] RST_OBSTACLE_ROW_MAX = 10'd239;
  localparam logic [ROW_W-1:0] RST_LINE_ROW_MIN     = 10'd115;
  localparam logic [ROW_W-1:0] RST_LINE_ROW_MAX     = 10'd239;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED_HUE_LOW_MAX  = 3'd0,
    REG_RED_HUE_HIGH_MIN = 3'd1,
    REG_ORANGE_HUE_MIN   = 3'd2,
    REG_ORANGE_HUE_MAX   = 3'd3,
    REG_OBSTACLE_ROW_MIN = 3'd4,
    REG_OBSTACLE_ROW_MAX = 3'd5,
    REG_LINE_ROW_MIN     = 3'd6,
    REG_LINE_ROW_MAX     = 3'd7
  } cfg_index_t;

  // Output classes.
  typedef enum logic [CLS_W-1:0] {
    CLS_NONE   = 3'd0,
    CLS_RED    = 3'd1,
    CLS_GREEN  = 3'd2,
    CLS_ORANGE = 3'd3,
    CLS_BLUE   = 3'd4
  } color_class_t;

  // Which channel is the largest, tested red first, then green.
  typedef enum logic [1:0] {
    SECT_RED   = 2'd0,
    SECT_GREEN = 2'd1,
    SECT_BLUE  = 2'd2
  } sector_t;

  // Configuration registers as seen by the classifier.
  typedef struct packed {
    logic [HUE_W-1:0] red_hue_low_max;
    logic [HUE_W-1:0] red_hue_high_min;
    logic [HUE_W-1:0] orange_hue_min;
    logic [HUE_W-1:0] orange_hue_max;
    logic [ROW_W-1:0] obstacle_row_min;
    logic [ROW_W-1:0] obstacle_row_max;
    logic [ROW_W-1:0] line_row_min;
    logic [ROW_W-1:0] line_row_max;
  } cfg_regs_t;

  // Side data that rides along with the hue division.
  typedef struct packed {
    logic             neg;
    sector_t          sector;
    logic [ROW_W-1:0] row;
  } hue_side_t;

  // Front end results handed to the two dividers.
  typedef struct packed {
    logic [SAT_NUM_W-1:0] sat_num;
    logic [DIV_DEN_W-1:0] sat_den;
    logic [HUE_NUM_W-1:0] hue_num;
    logic [DIV_DEN_W-1:0] hue_den;
    hue_side_t            side;
    logic [CH_W-1:0]      value;
  } front_out_t;

endpackage

// ===== rtl/rgb565_hsv_color_classifier_top.sv =====
// RGB565 to HSV color classifier. The block takes one pixel with its row on
// every clock (busy never rises) and returns one result per pixel, marked by
// done. Two front-end stages widen the channels and form the numerators, two
// eight-stage restoring dividers (hue and saturation, one quotient bit per
// stage) run side by side, and two final stages finish the hue and apply the
// class rules and row windows. Results appear in input order and cannot be
// held off, so the receiver must take every done beat. Registers are written
// through the cfg channel, which is always ready; write them only while no
// pixel is in flight.
module rgb565_hsv_color_classifier_top
  import rhc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [PIXEL_W-1:0]    pixel,
  input  logic [ROW_W-1:0]      row,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output logic [CLS_W-1:0]      color_class,
  output logic [HUE_W-1:0]      hue,
  output logic [CH_W-1:0]       saturation,
  output logic [CH_W-1:0]       brightness
);

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  cfg_regs_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.red_hue_low_max  <= RST_RED_HUE_LOW_MAX;
      cfg.red_hue_high_min <= RST_RED_HUE_HIGH_MIN;
      cfg.orange_hue_min   <= RST_ORANGE_HUE_MIN;
      cfg.orange_hue_max   <= RST_ORANGE_HUE_MAX;
      cfg.obstacle_row_min <= RST_OBSTACLE_ROW_MIN;
      cfg.obstacle_row_max <= RST_OBSTACLE_ROW_MAX;
      cfg.line_row_min     <= RST_LINE_ROW_MIN;
      cfg.line_row_max     <= RST_LINE_ROW_MAX;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        REG_RED_HUE_LOW_MAX:  cfg.red_hue_low_max  <= cfg_data[HUE_W-1:0];
        REG_RED_HUE_HIGH_MIN: cfg.red_hue_high_min <= cfg_data[HUE_W-1:0];
        REG_ORANGE_HUE_MIN:   cfg.orange_hue_min   <= cfg_data[HUE_W-1:0];
        REG_ORANGE_HUE_MAX:   cfg.orange_hue_max   <= cfg_data[HUE_W-1:0];
        REG_OBSTACLE_ROW_MIN: cfg.obstacle_row_min <= cfg_data[ROW_W-1:0];
        REG_OBSTACLE_ROW_MAX: cfg.obstacle_row_max <= cfg_data[ROW_W-1:0];
        REG_LINE_ROW_MIN:     cfg.line_row_min     <= cfg_data[ROW_W-1:0];
        REG_LINE_ROW_MAX:     cfg.line_row_max     <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: channel widening, extremes and numerators.
  logic       front_valid;
  front_out_t front_data;

  rhc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .pixel     (pixel),
    .row       (row),
    .out_valid (front_valid),
    .out_data  (front_data)
  );

  // Hue and saturation dividers in parallel.
  logic                 hue_valid;
  logic [DIV_QUO_W-1:0] hue_quo;
  hue_side_t            hue_side;
  logic                 sat_valid;
  logic [DIV_QUO_W-1:0] sat_quo;
  logic [CH_W-1:0]      sat_value;

  rhc_div #(
    .NUM_W  (HUE_NUM_W),
    .DEN_W  (DIV_DEN_W),
    .QUO_W  (DIV_QUO_W),
    .SIDE_W ($bits(hue_side_t))
  ) u_hue_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .num       (front_data.hue_num),
    .den       (front_data.hue_den),
    .side_in   (front_data.side),
    .out_valid (hue_valid),
    .quo       (hue_quo),
    .side_out  (hue_side)
  );

  rhc_div #(
    .NUM_W  (SAT_NUM_W),
    .DEN_W  (DIV_DEN_W),
    .QUO_W  (DIV_QUO_W),
    .SIDE_W (CH_W)
  ) u_sat_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .num       (front_data.sat_num),
    .den       (front_data.sat_den),
    .side_in   (front_data.value),
    .out_valid (sat_valid),
    .quo       (sat_quo),
    .side_out  (sat_value)
  );

  // Hue completion and classification.
  rhc_classify u_classify (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (hue_valid && sat_valid),
    .hue_quo     (hue_quo),
    .hue_side    (hue_side),
    .sat_quo     (sat_quo),
    .value       (sat_value),
    .done        (done),
    .color_class (color_class),
    .hue         (hue),
    .saturation  (saturation),
    .brightness  (brightness)
  );

endmodule

// ===== rtl/rhc_front.sv =====
module rhc_front
  import rhc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [PIXEL_W-1:0] pixel,
  input  logic [ROW_W-1:0]   row,
  output logic               out_valid,
  output front_out_t         out_data
);

  // Stage one registers.
  logic            s1_valid;
  logic [CH_W-1:0] s1_r;
  logic [CH_W-1:0] s1_g;
  logic [CH_W-1:0] s1_b;
  logic [CH_W-1:0] s1_max;
  logic [CH_W-1:0] s1_min;
  sector_t         s1_sector;
  logic [ROW_W-1:0] s1_row;

  logic [CH_W-1:0] r_wide;
  logic [CH_W-1:0] g_wide;
  logic [CH_W-1:0] b_wide;
  sector_t         sector_next;
  logic [CH_W-1:0] max_next;
  logic [CH_W-1:0] min_next;

  // Widen the channels by bit replication and find the largest and smallest.
  always_comb begin
    r_wide = {pixel[15:11], pixel[15:13]};
    g_wide = {pixel[10:5], pixel[10:9]};
    b_wide = {pixel[4:0], pixel[4:2]};
    if (r_wide >= g_wide && r_wide >= b_wide) begin
      sector_next = SECT_RED;
      max_next    = r_wide;
    end else if (g_wide >= b_wide) begin
      sector_next = SECT_GREEN;
      max_next    = g_wide;
    end else begin
      sector_next = SECT_BLUE;
      max_next    = b_wide;
    end
    min_next = r_wide;
    if (g_wide < min_next) begin
      min_next = g_wide;
    end
    if (b_wide < min_next) begin
      min_next = b_wide;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_r      <= r_wide;
    s1_g      <= g_wide;
    s1_b      <= b_wide;
    s1_max    <= max_next;
    s1_min    <= min_next;
    s1_sector <= sector_next;
    s1_row    <= row;
  end

  // Stage two: spread, hue difference and the two numerators.
  logic [CH_W-1:0] delta;
  logic [CH_W-1:0] op_a;
  logic [CH_W-1:0] op_b;
  logic            diff_neg;
  logic [CH_W-1:0] diff_abs;
  front_out_t      data_next;

  always_comb begin
    delta = s1_max - s1_min;
    case (s1_sector)
      SECT_RED: begin
        op_a = s1_g;
        op_b = s1_b;
      end
      SECT_GREEN: begin
        op_a = s1_b;
        op_b = s1_r;
      end
      default: begin
        op_a = s1_r;
        op_b = s1_g;
      end
    endcase
    diff_neg = op_a < op_b;
    diff_abs = diff_neg ? (op_b - op_a) : (op_a - op_b);

    data_next.side.neg    = diff_neg;
    data_next.side.sector = s1_sector;
    data_next.side.row    = s1_row;
    data_next.value       = s1_max;

    // A black pixel gives zero saturation: divide zero by one.
    if (s1_max == '0) begin
      data_next.sat_num = '0;
      data_next.sat_den = DIV_DEN_W'(1);
    end else begin
      data_next.sat_num = {delta, 8'h00} - SAT_NUM_W'(delta);
      data_next.sat_den = s1_max;
    end

    // A grey pixel gives zero hue.
    if (delta == '0) begin
      data_next.hue_num = '0;
      data_next.hue_den = DIV_DEN_W'(1);
    end else begin
      data_next.hue_num = {diff_abs, 6'b0} - HUE_NUM_W'({diff_abs, 2'b0});
      data_next.hue_den = delta;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= data_next;
  end

endmodule

// ===== rtl/rhc_div.sv =====
module rhc_div
  import rhc_pkg::*;
#(
  parameter int NUM_W  = SAT_NUM_W,
  parameter int DEN_W  = DIV_DEN_W,
  parameter int QUO_W  = DIV_QUO_W,
  parameter int SIDE_W = CH_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [QUO_W-1:0]  quo,
  output logic [SIDE_W-1:0] side_out
);

  // Restoring division, one quotient bit per stage, most significant first.
  // The numerator must be below den * 2**QUO_W.
  localparam int WIDE_W = NUM_W + DEN_W + QUO_W;

  logic [NUM_W-1:0]  rem_q   [1:QUO_W-1];
  logic [DEN_W-1:0]  den_q   [1:QUO_W-1];
  logic [QUO_W-1:0]  quo_q   [1:QUO_W];
  logic [SIDE_W-1:0] side_q  [1:QUO_W];
  logic              valid_q [1:QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    logic [NUM_W-1:0]  rem_cur;
    logic [DEN_W-1:0]  den_cur;
    logic [QUO_W-1:0]  quo_cur;
    logic [SIDE_W-1:0] side_cur;
    logic              valid_cur;
    logic [WIDE_W-1:0] trial;
    logic              fits;

    if (s == 0) begin : g_first
      assign rem_cur   = num;
      assign den_cur   = den;
      assign quo_cur   = '0;
      assign side_cur  = side_in;
      assign valid_cur = in_valid;
    end else begin : g_rest
      assign rem_cur   = rem_q[s];
      assign den_cur   = den_q[s];
      assign quo_cur   = quo_q[s];
      assign side_cur  = side_q[s];
      assign valid_cur = valid_q[s];
    end

    // Try to take away the divisor at this bit's weight.
    assign trial = WIDE_W'(den_cur) << (QUO_W - 1 - s);
    assign fits  = WIDE_W'(rem_cur) >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[s+1] <= 1'b0;
      end else begin
        valid_q[s+1] <= valid_cur;
      end
    end

    always_ff @(posedge clk) begin
      quo_q[s+1]  <= QUO_W'({quo_cur, fits});
      side_q[s+1] <= side_cur;
    end

    // The last stage needs no remainder or divisor.
    if (s < QUO_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_q[s+1] <= fits ? NUM_W'(WIDE_W'(rem_cur) - trial) : rem_cur;
        den_q[s+1] <= den_cur;
      end
    end
  end

  assign out_valid = valid_q[QUO_W];
  assign quo       = quo_q[QUO_W];
  assign side_out  = side_q[QUO_W];

endmodule

// ===== rtl/rhc_classify.sv =====
module rhc_classify
  import rhc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_regs_t            cfg,
  input  logic                 in_valid,
  input  logic [DIV_QUO_W-1:0] hue_quo,
  input  hue_side_t            hue_side,
  input  logic [DIV_QUO_W-1:0] sat_quo,
  input  logic [CH_W-1:0]      value,
  output logic                 done,
  output logic [CLS_W-1:0]     color_class,
  output logic [HUE_W-1:0]     hue,
  output logic [CH_W-1:0]      saturation,
  output logic [CH_W-1:0]      brightness
);

  localparam logic [HUE_W-1:0] HUE_GREEN_BASE = 9'd120;
  localparam logic [HUE_W-1:0] HUE_BLUE_BASE  = 9'd240;
  localparam logic [HUE_W-1:0] HUE_FULL       = 9'd360;
  localparam logic [HUE_W-1:0] GREEN_HUE_MIN  = 9'd45;
  localparam logic [HUE_W-1:0] GREEN_HUE_MAX  = 9'd180;
  localparam logic [HUE_W-1:0] BLUE_HUE_MIN   = 9'd200;
  localparam logic [HUE_W-1:0] BLUE_HUE_MAX   = 9'd270;
  localparam logic [CH_W-1:0]  DARK_VAL       = 8'd20;
  localparam logic [CH_W-1:0]  ORANGE_MIN_SAT = 8'd90;
  localparam logic [CH_W-1:0]  ORANGE_MIN_VAL = 8'd60;
  localparam logic [CH_W-1:0]  GREEN_MIN_SAT  = 8'd30;
  localparam logic [CH_W-1:0]  GREEN_MAX_VAL  = 8'd100;
  localparam logic [CH_W-1:0]  BLUE_MIN_SAT   = 8'd45;
  localparam logic [CH_W-1:0]  BLUE_MIN_VAL   = 8'd45;

  // Stage one: finish the hue from the sector offset and the signed quotient.
  logic                    h_valid;
  logic [HUE_W-1:0]        h_hue;
  logic [CH_W-1:0]         h_sat;
  logic [CH_W-1:0]         h_val;
  logic [ROW_W-1:0]        h_row;
  logic [HUE_W-1:0]        base;
  logic signed [HUE_W+1:0] hue_sum;
  logic [HUE_W-1:0]        hue_next;

  always_comb begin
    case (hue_side.sector)
      SECT_RED:   base = '0;
      SECT_GREEN: base = HUE_GREEN_BASE;
      default:    base = HUE_BLUE_BASE;
    endcase
    if (hue_side.neg) begin
      hue_sum = $signed({2'b00, base}) - $signed((HUE_W+2)'(hue_quo));
    end else begin
      hue_sum = $signed({2'b00, base}) + $signed((HUE_W+2)'(hue_quo));
    end
    // A negative hue wraps around the circle.
    if (hue_sum < 0) begin
      hue_sum = hue_sum + $signed({2'b00, HUE_FULL});
    end
    hue_next = hue_sum[HUE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
    end else begin
      h_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    h_hue <= hue_next;
    h_sat <= sat_quo;
    h_val <= value;
    h_row <= hue_side.row;
  end

  // Stage two: class rules in priority order, then the row windows.
  color_class_t cls_rule;
  color_class_t cls_next;
  logic         in_obstacle;
  logic         in_line;

  always_comb begin
    if (h_val < DARK_VAL) begin
      cls_rule = CLS_NONE;
    end else if ((h_hue <= cfg.red_hue_low_max || h_hue >= cfg.red_hue_high_min) &&
                 h_sat >= RED_MIN_SAT && h_val >= RED_MIN_VAL) begin
      cls_rule = CLS_RED;
    end else if (h_hue >= cfg.orange_hue_min && h_hue <= cfg.orange_hue_max &&
                 h_sat >= ORANGE_MIN_SAT && h_val >= ORANGE_MIN_VAL) begin
      cls_rule = CLS_ORANGE;
    end else if (h_hue >= GREEN_HUE_MIN && h_hue <= GREEN_HUE_MAX &&
                 h_sat >= GREEN_MIN_SAT && h_val <= GREEN_MAX_VAL) begin
      cls_rule = CLS_GREEN;
    end else if (h_hue >= BLUE_HUE_MIN && h_hue <= BLUE_HUE_MAX &&
                 h_sat >= BLUE_MIN_SAT && h_val >= BLUE_MIN_VAL) begin
      cls_rule = CLS_BLUE;
    end else begin
      cls_rule = CLS_NONE;
    end

    in_obstacle = h_row >= cfg.obstacle_row_min && h_row <= cfg.obstacle_row_max;
    in_line     = h_row >= cfg.line_row_min && h_row <= cfg.line_row_max;

    case (cls_rule) inside
      CLS_RED, CLS_GREEN:   cls_next = in_obstacle ? cls_rule : CLS_NONE;
      CLS_ORANGE, CLS_BLUE: cls_next = in_line ? cls_rule : CLS_NONE;
      default:              cls_next = CLS_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= h_valid;
    end
  end

  always_ff @(posedge clk) begin
    color_class <= cls_next;
    hue         <= h_hue;
    saturation  <= h_sat;
    brightness  <= h_val;
  end

endmodule
